### hdl/dcd_pkg.sv
package dcd_pkg;

  localparam int unsigned NOW_W   = 32;
  localparam int unsigned LIGHT_W = 10;
  localparam int unsigned ECHO_W  = 16;
  localparam int unsigned DIST_W  = 14;
  localparam int unsigned PHASE_W = 2;
  localparam int unsigned MS_W    = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // echo * 17 / 100 as one multiply by 17 * ceil(2^27 / 100), exact for 16-bit echo
  localparam int unsigned MM_SHIFT  = 27;
  localparam int unsigned MM_MULT_W = 25;
  localparam logic [MM_MULT_W-1:0] MM_MULT = 25'd22817026;
  localparam int unsigned MM_PROD_W = ECHO_W + MM_MULT_W;

  localparam logic [LIGHT_W-1:0] BEAM_THRESHOLD_RST  = 10'd512;
  localparam logic [MS_W-1:0]    SAMPLE_INTERVAL_RST = 16'd100;
  localparam logic [MS_W-1:0]    FINISH_DELAY_RST    = 16'd500;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BEAM_THRESHOLD  = 2'd0,
    CFG_SAMPLE_INTERVAL = 2'd1,
    CFG_FINISH_DELAY    = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_START = 4'b0010,
    PH_BUSY  = 4'b0100,
    PH_DONE  = 4'b1000
  } phase_t;

  localparam logic [PHASE_W-1:0] PHASE_CODE_IDLE  = 2'd0;
  localparam logic [PHASE_W-1:0] PHASE_CODE_START = 2'd1;
  localparam logic [PHASE_W-1:0] PHASE_CODE_BUSY  = 2'd2;
  localparam logic [PHASE_W-1:0] PHASE_CODE_DONE  = 2'd3;

  typedef struct packed {
    logic [LIGHT_W-1:0] beam_threshold;
    logic [MS_W-1:0]    sample_interval_ms;
    logic [MS_W-1:0]    finish_delay_ms;
  } cfg_t;

  typedef struct packed {
    logic [NOW_W-1:0]   now_ms;
    logic [LIGHT_W-1:0] light_level;
    logic [ECHO_W-1:0]  echo_us;
  } item_t;

  typedef struct packed {
    logic               entered;
    logic               exited;
    logic               approaching;
    logic               receding;
    logic [PHASE_W-1:0] phase;
    logic [DIST_W-1:0]  distance_mm;
  } res_t;

  function automatic logic [PHASE_W-1:0] phase_code(input phase_t ph);
    logic [PHASE_W-1:0] code;
    case (ph)
      PH_IDLE:  code = PHASE_CODE_IDLE;
      PH_START: code = PHASE_CODE_START;
      PH_BUSY:  code = PHASE_CODE_BUSY;
      PH_DONE:  code = PHASE_CODE_DONE;
      default:  code = PHASE_CODE_IDLE;
    endcase
    return code;
  endfunction

  function automatic logic [DIST_W-1:0] echo_to_mm(input logic [ECHO_W-1:0] echo);
    logic [MM_PROD_W-1:0] prod;
    prod = MM_PROD_W'(echo) * MM_PROD_W'(MM_MULT);
    return prod[MM_SHIFT +: DIST_W];
  endfunction

endpackage

### hdl/dcd_in_if.sv
interface dcd_in_if;
  logic                              valid;
  logic                              ready;
  logic [dcd_pkg::NOW_W-1:0]   now_ms;
  logic [dcd_pkg::LIGHT_W-1:0] light_level;
  logic [dcd_pkg::ECHO_W-1:0]  echo_us;

  modport source (output valid, now_ms, light_level, echo_us, input ready);
  modport sink   (input valid, now_ms, light_level, echo_us, output ready);
endinterface

### hdl/dcd_out_if.sv
interface dcd_out_if;
  logic                              valid;
  logic                              ready;
  logic                              entered;
  logic                              exited;
  logic                              approaching;
  logic                              receding;
  logic [dcd_pkg::PHASE_W-1:0] phase;
  logic [dcd_pkg::DIST_W-1:0]  distance_mm;

  modport source (output valid, entered, exited, approaching, receding, phase, distance_mm,
                  input ready);
  modport sink   (input valid, entered, exited, approaching, receding, phase, distance_mm,
                  output ready);
endinterface

### hdl/dcd_cfg_if.sv
interface dcd_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [dcd_pkg::CFG_IDX_W-1:0]  index;
  logic [dcd_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### hdl/dcd_regs.sv
module dcd_regs (
  input  logic          clk,
  input  logic          rst_n,
  dcd_cfg_if.sink       cfg_ch,
  output dcd_pkg::cfg_t cfg
);

  dcd_pkg::cfg_t cfg_r, cfg_nxt;

  assign cfg_ch.ready = 1'b1;
  assign cfg          = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        dcd_pkg::CFG_BEAM_THRESHOLD:
          cfg_nxt.beam_threshold = cfg_ch.data[dcd_pkg::LIGHT_W-1:0];
        dcd_pkg::CFG_SAMPLE_INTERVAL:
          cfg_nxt.sample_interval_ms = cfg_ch.data[dcd_pkg::MS_W-1:0];
        dcd_pkg::CFG_FINISH_DELAY:
          cfg_nxt.finish_delay_ms = cfg_ch.data[dcd_pkg::MS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.beam_threshold     <= dcd_pkg::BEAM_THRESHOLD_RST;
      cfg_r.sample_interval_ms <= dcd_pkg::SAMPLE_INTERVAL_RST;
      cfg_r.finish_delay_ms    <= dcd_pkg::FINISH_DELAY_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

### hdl/dcd_track.sv
module dcd_track (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           take,
  input  dcd_pkg::item_t item,
  input  dcd_pkg::cfg_t  cfg,
  output dcd_pkg::res_t  res
);

  dcd_pkg::phase_t                 phase_r, phase_nxt;
  logic [dcd_pkg::DIST_W-1:0]      start_r, start_nxt;
  logic [dcd_pkg::DIST_W-1:0]      cur_r, cur_nxt;
  logic [dcd_pkg::DIST_W-1:0]      prev_r, prev_nxt;
  logic [dcd_pkg::NOW_W-1:0]       last_beam_r, last_beam_nxt;
  logic [dcd_pkg::NOW_W-1:0]       last_sample_r, last_sample_nxt;
  logic                            sampled_r, sampled_nxt;

  logic [dcd_pkg::NOW_W-1:0] since_sample;
  logic [dcd_pkg::NOW_W-1:0] since_beam;
  logic                      sample;
  logic                      beam;
  logic                      done;
  logic                      both;

  assign since_sample = item.now_ms - last_sample_r;
  assign since_beam   = item.now_ms - last_beam_r;
  assign sample = !sampled_r ||
                  (since_sample >= dcd_pkg::NOW_W'(cfg.sample_interval_ms));
  assign beam   = item.light_level > cfg.beam_threshold;

  always_comb begin
    cur_nxt         = cur_r;
    prev_nxt        = prev_r;
    last_sample_nxt = last_sample_r;
    sampled_nxt     = sampled_r;
    if (sample) begin
      prev_nxt        = cur_r;
      cur_nxt         = dcd_pkg::echo_to_mm(item.echo_us);
      last_sample_nxt = item.now_ms;
      sampled_nxt     = 1'b1;
    end

    phase_nxt     = phase_r;
    start_nxt     = start_r;
    last_beam_nxt = beam ? item.now_ms : last_beam_r;
    case (phase_r)
      dcd_pkg::PH_IDLE: begin
        if (beam) begin
          phase_nxt = dcd_pkg::PH_START;
          start_nxt = cur_nxt;
        end
      end
      dcd_pkg::PH_START: begin
        if (beam) phase_nxt = dcd_pkg::PH_BUSY;
      end
      dcd_pkg::PH_BUSY: begin
        if (!beam && (since_beam > dcd_pkg::NOW_W'(cfg.finish_delay_ms)))
          phase_nxt = dcd_pkg::PH_DONE;
      end
      dcd_pkg::PH_DONE: begin
        if (!beam) phase_nxt = dcd_pkg::PH_IDLE;
      end
      default: phase_nxt = dcd_pkg::PH_IDLE;
    endcase
  end

  assign done = (phase_nxt == dcd_pkg::PH_DONE);
  assign both = (prev_nxt != '0) && (cur_nxt != '0);

  always_comb begin
    res.entered     = done && (cur_nxt < start_nxt);
    res.exited      = done && (cur_nxt > start_nxt);
    res.approaching = both && (cur_nxt < prev_nxt);
    res.receding    = both && (cur_nxt > prev_nxt);
    res.phase       = dcd_pkg::phase_code(phase_nxt);
    res.distance_mm = cur_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= dcd_pkg::PH_IDLE;
      start_r       <= '0;
      cur_r         <= '0;
      prev_r        <= '0;
      last_beam_r   <= '0;
      last_sample_r <= '0;
      sampled_r     <= 1'b0;
    end else if (take) begin
      phase_r       <= phase_nxt;
      start_r       <= start_nxt;
      cur_r         <= cur_nxt;
      prev_r        <= prev_nxt;
      last_beam_r   <= last_beam_nxt;
      last_sample_r <= last_sample_nxt;
      sampled_r     <= sampled_nxt;
    end
  end

endmodule

### hdl/doorway_crossing_direction.sv
// Channel  Dir  Transaction                                   Handshake
// in_ch    in   now_ms[31:0], light_level[9:0], echo_us[15:0]  valid/ready
// out_ch   out  entered, exited, approaching, receding,        valid/ready
//               phase[1:0], distance_mm[13:0]
// cfg_ch   in   index[1:0], data[15:0]                          valid/ready, ready held high
//
// Path from input transaction to result: input register, then one pass of
// tracking logic into the result register. One transaction per cycle sustained while out_ch.ready is high.
// rst_n is synchronous; it clears the tracking state and restores register defaults.
// A stalled result holds the result register; the input register takes one more
// transaction if it is empty and holds it until the result is taken.
module doorway_crossing_direction (
  input  logic      clk,
  input  logic      rst_n,
  dcd_in_if.sink    in_ch,
  dcd_out_if.source out_ch,
  dcd_cfg_if.sink   cfg_ch
);

  dcd_pkg::cfg_t  cfg;
  dcd_pkg::item_t item_r, item_nxt;
  dcd_pkg::res_t  res_r, res_nxt;
  dcd_pkg::res_t  res_calc;
  logic           v1_r, v1_nxt;
  logic           v2_r, v2_nxt;
  logic           adv2;
  logic           take;
  logic           in_acc;

  dcd_regs u_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  dcd_track u_track (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (take),
    .item  (item_r),
    .cfg   (cfg),
    .res   (res_calc)
  );

  assign adv2        = !v2_r || out_ch.ready;
  assign take        = v1_r && adv2;
  assign in_ch.ready = !v1_r || adv2;
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_comb begin
    item_nxt = item_r;
    if (in_acc) begin
      item_nxt.now_ms      = in_ch.now_ms;
      item_nxt.light_level = in_ch.light_level;
      item_nxt.echo_us     = in_ch.echo_us;
    end
    v1_nxt  = in_acc ? 1'b1 : (take ? 1'b0 : v1_r);
    v2_nxt  = adv2 ? v1_r : v2_r;
    res_nxt = take ? res_calc : res_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    res_r  <= res_nxt;
  end

  assign out_ch.valid       = v2_r;
  assign out_ch.entered     = res_r.entered;
  assign out_ch.exited      = res_r.exited;
  assign out_ch.approaching = res_r.approaching;
  assign out_ch.receding    = res_r.receding;
  assign out_ch.phase       = res_r.phase;
  assign out_ch.distance_mm = res_r.distance_mm;

  a_dir_excl: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> !(res_r.entered && res_r.exited) && !(res_r.approaching && res_r.receding))
    else $error("conflicting direction flags");

  a_dir_done: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r && (res_r.entered || res_r.exited) |-> res_r.phase == dcd_pkg::PHASE_CODE_DONE)
    else $error("direction reported outside finished phase");

  a_hold_in: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r && !adv2 |=> v1_r && $stable(item_r))
    else $error("input stage lost a stalled transaction");

  a_take_out: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> v2_r)
    else $error("processed transaction not presented");

endmodule
